/* hdl/otfla_pkg.sv */
package otfla_pkg;

  localparam int MAX_SERVERS_DEF = 8;
  localparam int SERVERS_RESET   = 5;
  localparam int CFG_W           = 4;
  localparam int ADDR_W          = 32;
  localparam int STATUS_W        = 2;
  localparam int SIDX_W          = 3;
  localparam int OUT_W           = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_ASSIGNED  = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    FN_OPEN  = 1'b0,
    FN_CLOSE = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_OPEN,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic latch_req;
    logic open_take;
    logic scan_start;
    logic scan_next;
    logic rel_take;
    logic shift_wr;
    logic shift_end;
    logic set_none;
    logic set_notfound;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  free_empty;
    logic  act_empty;
    logic  match;
    logic  scan_last;
    logic  shift_done;
    logic  out_free;
  } dp_sts_t;

endpackage

/* hdl/owner_tagged_free_list_allocator_top.sv */
// open: latch, dispatch, take from the free queue, finish; no take when no server is free
// close: dispatch, a read and a compare state per active entry scanned, then on a release a
// read and a write state per entry shifted, set by the registered read of the active list
// one request in flight; the next word is taken the cycle after the result is registered
// reset: free queue holds servers 0 to 4 in order, no active entries, no clearing pass
// a configuration write reloads the free queue the same way with the new count
module owner_tagged_free_list_allocator_top #(
  parameter int MaxServers = otfla_pkg::MAX_SERVERS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [otfla_pkg::ADDR_W-1:0] s_tdata_i,   // client_addr
  input  logic                         s_tuser_i,   // func
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [otfla_pkg::OUT_W-1:0]  m_tdata_o,   // status, server_index, zero pad
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [otfla_pkg::CFG_W-1:0]  cfg_data_i
);
  import otfla_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  otfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  otfla_dp #(
    .MaxServers (MaxServers)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

/* hdl/otfla_ctrl.sv */
module otfla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  output logic               cfg_ready_o,
  input  otfla_pkg::dp_sts_t sts_i,
  output otfla_pkg::dp_cmd_t cmd_o
);
  import otfla_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    s_tready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o  = 1'b1;
        cfg_ready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.func == FN_CLOSE) begin
          if (sts_i.act_empty) begin
            cmd_o.set_notfound = 1'b1;
            state_d            = S_FINISH;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN_RD;
          end
        end else if (sts_i.free_empty) begin
          cmd_o.set_none = 1'b1;
          state_d        = S_FINISH;
        end else begin
          state_d = S_OPEN;
        end
      end
      S_OPEN: begin
        cmd_o.open_take = 1'b1;
        state_d         = S_FINISH;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.match) begin
          cmd_o.rel_take = 1'b1;
          state_d        = S_SHIFT_RD;
        end else if (sts_i.scan_last) begin
          cmd_o.set_notfound = 1'b1;
          state_d            = S_FINISH;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.shift_done) begin
          cmd_o.shift_end = 1'b1;
          state_d         = S_FINISH;
        end else begin
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* hdl/otfla_dp.sv */
module otfla_dp #(
  parameter int MaxServers = otfla_pkg::MAX_SERVERS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [otfla_pkg::ADDR_W-1:0]  s_tdata_i,
  input  logic                          s_tuser_i,
  input  logic                          cfg_we_i,
  input  logic [otfla_pkg::CFG_W-1:0]   cfg_data_i,
  input  otfla_pkg::dp_cmd_t            cmd_i,
  output otfla_pkg::dp_sts_t            sts_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [otfla_pkg::OUT_W-1:0]   m_tdata_o
);
  import otfla_pkg::*;

  localparam int IdxW   = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int CntW   = $clog2(MaxServers + 1);
  localparam int ClampW = (CntW > CFG_W) ? CntW : CFG_W;
  localparam int RstCnt = (SERVERS_RESET > MaxServers) ? MaxServers : SERVERS_RESET;
  localparam int EntW   = ADDR_W + IdxW;

  func_e               func_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [IdxW-1:0]     head_q;
  logic [CntW-1:0]     free_cnt_q;
  logic [CntW-1:0]     act_cnt_q;
  logic [CntW-1:0]     ptr_q;
  status_e             res_status_q;
  logic [IdxW-1:0]     res_idx_q;
  logic [MaxServers-1:0] ring_vld_q;
  logic [IdxW-1:0]     ring_mem [MaxServers];
  logic [IdxW-1:0]     ring_dat_q;
  logic                ring_hit_q;
  logic [EntW-1:0]     act_mem [MaxServers];
  logic [EntW-1:0]     act_rd_q;
  logic                m_valid_q;
  status_e             out_status_q;
  logic [SIDX_W-1:0]   out_idx_q;

  logic [ClampW-1:0]   cfg_ext;
  logic [CntW-1:0]     cfg_n;
  logic [CntW:0]       tail_sum;
  logic [IdxW-1:0]     tail_idx;
  logic [IdxW-1:0]     head_nxt;
  logic [IdxW-1:0]     ring_out;
  logic [CntW-1:0]     ptr_m1;
  logic                act_we;
  logic [IdxW-1:0]     act_waddr;
  logic [EntW-1:0]     act_wdata;

  // pool size from the register, clamped to 1..MaxServers
  always_comb begin
    cfg_ext = ClampW'(cfg_data_i);
    if (cfg_ext == '0) begin
      cfg_n = CntW'(1);
    end else if (cfg_ext > ClampW'(MaxServers)) begin
      cfg_n = CntW'(MaxServers);
    end else begin
      cfg_n = CntW'(cfg_ext);
    end
  end

  always_comb begin
    tail_sum = (CntW+1)'(head_q) + (CntW+1)'(free_cnt_q);
    if (tail_sum >= (CntW+1)'(MaxServers)) begin
      tail_sum = tail_sum - (CntW+1)'(MaxServers);
    end
    tail_idx = tail_sum[IdxW-1:0];
    head_nxt = (head_q == IdxW'(MaxServers - 1)) ? '0 : head_q + 1'b1;
    // an unwritten ring slot still holds its initial server number
    ring_out = ring_hit_q ? ring_dat_q : head_q;
    ptr_m1   = ptr_q - 1'b1;
  end

  always_comb begin
    act_we    = cmd_i.open_take | cmd_i.shift_wr;
    act_waddr = cmd_i.open_take ? act_cnt_q[IdxW-1:0] : ptr_m1[IdxW-1:0];
    act_wdata = cmd_i.open_take ? {addr_q, ring_out} : act_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      free_cnt_q <= CntW'(RstCnt);
      act_cnt_q  <= '0;
      ring_vld_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        head_q     <= '0;
        free_cnt_q <= cfg_n;
        act_cnt_q  <= '0;
        ring_vld_q <= '0;
      end
      if (cmd_i.open_take) begin
        head_q     <= head_nxt;
        free_cnt_q <= free_cnt_q - 1'b1;
        act_cnt_q  <= act_cnt_q + 1'b1;
      end
      if (cmd_i.shift_end) begin
        free_cnt_q           <= free_cnt_q + 1'b1;
        act_cnt_q            <= act_cnt_q - 1'b1;
        ring_vld_q[tail_idx] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_end) begin
      ring_mem[tail_idx] <= res_idx_q;
    end
    ring_dat_q <= ring_mem[head_q];
    ring_hit_q <= ring_vld_q[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_mem[act_waddr] <= act_wdata;
    end
    act_rd_q <= act_mem[ptr_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      func_q <= func_e'(s_tuser_i);
      addr_q <= s_tdata_i;
    end
    if (cmd_i.scan_start) begin
      ptr_q <= '0;
    end else if (cmd_i.scan_next || cmd_i.rel_take || cmd_i.shift_wr) begin
      ptr_q <= ptr_q + 1'b1;
    end
    if (cmd_i.open_take) begin
      res_status_q <= ST_ASSIGNED;
      res_idx_q    <= ring_out;
    end else if (cmd_i.rel_take) begin
      res_status_q <= ST_RELEASED;
      res_idx_q    <= act_rd_q[IdxW-1:0];
    end else if (cmd_i.set_none) begin
      res_status_q <= ST_NONE_FREE;
      res_idx_q    <= '0;
    end else if (cmd_i.set_notfound) begin
      res_status_q <= ST_NOT_FOUND;
      res_idx_q    <= '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_idx_q    <= SIDX_W'(res_idx_q);
    end
  end

  always_comb begin
    sts_o.func       = func_q;
    sts_o.free_empty = (free_cnt_q == '0);
    sts_o.act_empty  = (act_cnt_q == '0);
    sts_o.match      = (act_rd_q[EntW-1:IdxW] == addr_q);
    sts_o.scan_last  = ((CntW+1)'(ptr_q) + 1'b1 == (CntW+1)'(act_cnt_q));
    sts_o.shift_done = (ptr_q == act_cnt_q);
    sts_o.out_free   = !m_valid_q || m_tready_i;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{(OUT_W-STATUS_W-SIDX_W){1'b0}}, out_idx_q, out_status_q};

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CntW+1)'(free_cnt_q) + (CntW+1)'(act_cnt_q)) <= (CntW+1)'(MaxServers))
    else $error("free and active counts exceed pool");

  a_open_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.open_take |-> (free_cnt_q != '0))
    else $error("allocation from empty free queue");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> (ptr_q != '0 && ptr_q < act_cnt_q))
    else $error("active list shift out of range");

  a_release_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_end |-> (act_cnt_q != '0 && free_cnt_q < CntW'(MaxServers)))
    else $error("release with no active entry");

endmodule
